// ===== rtl/range_list_index_map_defines.svh =====
// Assertion macros for the range list index map.
`ifndef RANGE_LIST_INDEX_MAP_DEFINES_SVH
`define RANGE_LIST_INDEX_MAP_DEFINES_SVH

// Assert that an implication holds at every clock edge outside reset.
`define RLIM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Assert that the consequent holds in the cycle after the antecedent.
`define RLIM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/rlim_pkg.sv =====
// ----------------------------------------------------------------------------
// rlim_pkg
// Types and constants shared by the range list index map.
// ----------------------------------------------------------------------------
`default_nettype none
package rlim_pkg;
  localparam int MaxRanges = 256;
  localparam int IdxW      = $clog2(MaxRanges);
  localparam int CntW      = IdxW + 1;
  localparam int CpW       = 21;
  localparam int PosW      = 29;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_P2C    = 2'd2;
  localparam logic [1:0] CMD_C2P    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_BADRANGE = 2'd3;

  typedef struct packed {
    logic [1:0]      command;
    logic [CpW-1:0]  range_first;
    logic [CpW-1:0]  range_last;
    logic [PosW-1:0] list_position;
    logic [CpW-1:0]  code_point;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [PosW-1:0] answer;
    logic [PosW-1:0] total_count;
  } out_item_t;
endpackage
`default_nettype wire

// ===== rtl/rlim_front.sv =====
// ----------------------------------------------------------------------------
// rlim_front
// Two-entry command queue between the input port and the execution engine.
// ----------------------------------------------------------------------------
`default_nettype none
module rlim_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire rlim_pkg::in_item_t item,
  output logic                   cmd_valid,
  input  wire logic              cmd_take,
  output rlim_pkg::in_item_t     cmd_item
);
  import rlim_pkg::*;

  in_item_t   slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd_item  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_take && cmd_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, (push && !full)} - {1'b0, (cmd_take && cmd_valid)};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rlim_back.sv =====
// ----------------------------------------------------------------------------
// rlim_back
// Range table and sequencer: append, clear and the linear and binary searches.
// ----------------------------------------------------------------------------
`default_nettype none
module rlim_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_take,
  input  wire rlim_pkg::in_item_t cmd_item,
  output logic                    empty,
  input  wire logic               pop,
  output rlim_pkg::out_item_t     result
);
  import rlim_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;

  logic [CpW-1:0]  first_mem [MaxRanges];
  logic [CpW-1:0]  last_mem  [MaxRanges];
  logic [PosW-1:0] base_mem  [MaxRanges];

  logic [2:0]      state;
  in_item_t        cur;
  logic [CntW-1:0] used_ranges;
  logic [PosW-1:0] running_total;
  logic [CntW-1:0] lo;
  logic [CntW-1:0] hi;
  logic [IdxW-1:0] addr;
  logic [CpW-1:0]  rd_first;
  logic [CpW-1:0]  rd_last;
  logic [PosW-1:0] rd_base;
  logic            out_valid;
  out_item_t       out_reg;

  logic [CntW-1:0] mid;
  logic [PosW:0]   append_sum;
  logic [PosW-1:0] span_end;
  logic            app_ok;
  logic [1:0]      app_status;

  assign empty    = !out_valid;
  assign result   = out_reg;
  assign cmd_take = (state == S_IDLE) && cmd_valid && !out_valid;

  assign mid        = lo + ((hi - lo) >> 1);
  assign span_end   = rd_base + PosW'(rd_last - rd_first);
  assign append_sum = {1'b0, running_total}
                      + (PosW + 1)'(cmd_item.range_last - cmd_item.range_first) + 1'b1;

  always_comb begin
    app_ok = 1'b0;
    if (used_ranges >= CntW'(MaxRanges)) begin
      app_status = ST_FULL;
    end else if (cmd_item.range_last < cmd_item.range_first) begin
      app_status = ST_BADRANGE;
    end else if (append_sum > (PosW + 1)'({PosW{1'b1}})) begin
      app_status = ST_FULL;
    end else begin
      app_status = ST_OK;
      app_ok     = 1'b1;
    end
  end

  // Table write on an accepted append.
  always_ff @(posedge clk) begin
    if (cmd_take && cmd_item.command == CMD_APPEND && app_ok) begin
      first_mem[used_ranges[IdxW-1:0]] <= cmd_item.range_first;
      last_mem[used_ranges[IdxW-1:0]]  <= cmd_item.range_last;
      base_mem[used_ranges[IdxW-1:0]]  <= running_total;
    end
  end

  // Registered table read.
  always_ff @(posedge clk) begin
    rd_first <= first_mem[addr];
    rd_last  <= last_mem[addr];
    rd_base  <= base_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      used_ranges   <= '0;
      running_total <= '0;
      out_valid     <= 1'b0;
      lo            <= '0;
      hi            <= '0;
      addr          <= '0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_take) begin
            cur <= cmd_item;
            unique case (cmd_item.command)
              CMD_CLEAR: begin
                used_ranges   <= '0;
                running_total <= '0;
                out_reg       <= '{status: ST_OK, answer: '0, total_count: '0};
                out_valid     <= 1'b1;
              end
              CMD_APPEND: begin
                if (app_ok) begin
                  used_ranges   <= used_ranges + 1'b1;
                  running_total <= append_sum[PosW-1:0];
                end
                out_reg <= '{status: app_status, answer: '0,
                             total_count: app_ok ? append_sum[PosW-1:0] : running_total};
                out_valid <= 1'b1;
              end
              default: begin
                lo    <= '0;
                hi    <= used_ranges;
                state <= S_READ;
              end
            endcase
          end
        end
        S_READ: begin
          // Issue the probe address for the next step, or finish on miss.
          if (lo >= hi) begin
            out_reg   <= '{status: ST_NOTFOUND, answer: '0, total_count: running_total};
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            addr  <= (cur.command == CMD_P2C) ? mid[IdxW-1:0] : lo[IdxW-1:0];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (cur.command == CMD_P2C) begin
            if (cur.list_position > span_end) begin
              lo    <= {1'b0, addr} + 1'b1;
              state <= S_READ;
            end else if (cur.list_position < rd_base) begin
              hi    <= {1'b0, addr};
              state <= S_READ;
            end else begin
              out_reg <= '{status: ST_OK,
                           answer: PosW'(rd_first) + (cur.list_position - rd_base),
                           total_count: running_total};
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end
          end else begin
            if (cur.code_point >= rd_first && cur.code_point <= rd_last) begin
              out_reg <= '{status: ST_OK,
                           answer: rd_base + PosW'(cur.code_point - rd_first),
                           total_count: running_total};
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end else begin
              lo    <= lo + 1'b1;
              state <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/range_list_index_map.sv =====
// ----------------------------------------------------------------------------
// range_list_index_map
// Ordered code-point range table with position/code-point translation.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter as a queue: transfer on push while full is low. Clear
//   empties the table, append adds a range, position-to-code runs a binary
//   search over range bases, code-to-position walks the table in order.
//   Results leave from a single result register: a result sits on result
//   while empty is low and transfers on pop.
//   Clear and append write their result as the command is taken. A
//   search steps through the READ, DONE and EVAL states for each table
//   probe, plus a final READ on a miss: up to nine probes for
//   position-to-code over 256 ranges and up to 256 for code-to-position,
//   set by the single read port of the range memories.
//   Input queue holds two commands, so the sender keeps pushing while the
//   engine works; a stalled receiver holds the result register and the
//   engine waits, then the queue fills and full rises.
//   Reset clears the count and running total; table contents need no
//   clearing since entries past the count are never used.
// ----------------------------------------------------------------------------
`default_nettype none
`include "range_list_index_map_defines.svh"
module range_list_index_map (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire rlim_pkg::in_item_t  item,
  output logic                     empty,
  input  wire logic                pop,
  output rlim_pkg::out_item_t      result
);
  import rlim_pkg::*;

  logic     cmd_valid;
  logic     cmd_take;
  in_item_t cmd_item;

  // Front: hold accepted commands.
  rlim_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd_item  (cmd_item)
  );

  // Back: execute one command at a time.
  rlim_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd_item  (cmd_item),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  // Engine only draws a command from a non-empty queue while its result slot is free.
  `RLIM_ASSERT_IMP(a_take_ok, clk, rst, cmd_take, cmd_valid && empty)
  // A result not popped stays.
  `RLIM_ASSERT_NEXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(result))
  // Results with a status other than OK report a zero answer.
  `RLIM_ASSERT_IMP(a_zero, clk, rst, !empty && result.status != ST_OK, result.answer == '0)
endmodule
`default_nettype wire

// ===== sim/tb_range_list_index_map.sv =====
// ----------------------------------------------------------------------------
// tb_range_list_index_map
// Self-checking bench for the range list index map: commands are pushed in
// bursts, results are popped under a stall pattern, and a predictor of the
// range table checks every result field in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_range_list_index_map;
  import rlim_pkg::*;

  localparam int CpMax     = 1114111;
  localparam int WatchLim  = 20000;
  localparam int NumRandom = 1000;

  // Predictor of the range table and scoreboard of expected results.
  class range_map_board;
    logic [CpW-1:0]  first_tab[MaxRanges];
    logic [CpW-1:0]  last_tab[MaxRanges];
    logic [PosW-1:0] base_tab[MaxRanges];
    int unsigned     used;
    logic [PosW-1:0] total;
    out_item_t       pending[$];
    int              errors;
    int              checked;
    int              cmd_seen[4];
    int              status_seen[4];

    function new();
      used = 0;
      total = '0;
      errors = 0;
      checked = 0;
    endfunction

    // Work out the result of one accepted command and queue it.
    function void note_command(in_item_t it);
      out_item_t r;
      longint unsigned sz;
      int lo, hi, mid;
      logic [31:0] span;
      r = '0;
      r.status = ST_OK;
      cmd_seen[it.command]++;
      case (it.command)
        CMD_CLEAR: begin
          used = 0;
          total = '0;
        end
        CMD_APPEND: begin
          sz = longint'(it.range_last) - longint'(it.range_first) + 1;
          if (used >= MaxRanges) r.status = ST_FULL;
          else if (it.range_last < it.range_first) r.status = ST_BADRANGE;
          else if (longint'(total) + sz > longint'(2**PosW - 1)) r.status = ST_FULL;
          else begin
            first_tab[used] = it.range_first;
            last_tab[used] = it.range_last;
            base_tab[used] = total;
            used++;
            total = total + PosW'(sz);
          end
        end
        CMD_P2C: begin
          r.status = ST_NOTFOUND;
          lo = 0;
          hi = used;
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            span = 32'(last_tab[mid]) - 32'(first_tab[mid]);
            if (32'(it.list_position) > 32'(base_tab[mid]) + span) lo = mid + 1;
            else if (it.list_position < base_tab[mid]) hi = mid;
            else begin
              r.status = ST_OK;
              r.answer = PosW'(32'(first_tab[mid]) + 32'(it.list_position)
                               - 32'(base_tab[mid]));
              break;
            end
          end
        end
        default: begin
          r.status = ST_NOTFOUND;
          for (int i = 0; i < used; i++) begin
            if (it.code_point >= first_tab[i] && it.code_point <= last_tab[i]) begin
              r.status = ST_OK;
              r.answer = PosW'(32'(base_tab[i]) + 32'(it.code_point) - 32'(first_tab[i]));
              break;
            end
          end
        end
      endcase
      r.total_count = total;
      pending.push_back(r);
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %0s: got %0d expected %0d (result %0d)", what, got, want, checked);
      errors++;
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("unexpected result %0d with nothing pending", checked);
        errors++;
        return;
      end
      want = pending.pop_front();
      status_seen[want.status]++;
      if (got.status !== want.status) report("status", 32'(got.status), 32'(want.status));
      if (got.answer !== want.answer) report("answer", 32'(got.answer), 32'(want.answer));
      if (got.total_count !== want.total_count)
        report("total_count", 32'(got.total_count), 32'(want.total_count));
      checked++;
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  logic      full;
  logic      empty;
  in_item_t  item = '0;
  out_item_t result;

  range_map_board board = new();
  in_item_t  stim[$];
  bit        stim_done = 1'b0;
  bit        hold_off = 1'b0;
  int        idle_cycles = 0;
  int        sent = 0;

  range_list_index_map i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Note transfers on both sides at the rising edge; drive watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        board.note_command(item);
        sent++;
      end
      if (pop && !empty) board.check_result(result);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchLim) begin
        $display("watchdog: no transfer for %0d cycles", WatchLim);
        $display("tb_range_list_index_map: FAIL");
        $finish;
      end
    end
  end

  function automatic in_item_t make_cmd(logic [1:0] cmd, int a, int b, int p, int c);
    in_item_t it;
    it.command = cmd;
    it.range_first = CpW'(a);
    it.range_last = CpW'(b);
    it.list_position = PosW'(p);
    it.code_point = CpW'(c);
    return it;
  endfunction

  // Random code point: half the time small, else up to CpMax or full field width.
  function automatic int rand_cp();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 2**CpW - 1);
      1: return $urandom_range(0, CpMax);
      default: return $urandom_range(0, 400);
    endcase
  endfunction

  function automatic in_item_t rand_cmd();
    in_item_t it;
    int a, w;
    it = '0;
    it.range_first = CpW'($urandom);
    it.range_last = CpW'($urandom);
    it.list_position = PosW'($urandom);
    it.code_point = CpW'($urandom);
    case ($urandom_range(0, 19))
      0: it.command = CMD_CLEAR;
      1, 2, 3, 4, 5, 6: begin
        it.command = CMD_APPEND;
        a = rand_cp();
        w = ($urandom_range(0, 9) == 0) ? -$urandom_range(1, 5) : $urandom_range(0, 40);
        if ($urandom_range(0, 15) == 0) w = $urandom_range(0, 2**CpW - 1);
        it.range_first = CpW'(a);
        it.range_last = CpW'(a + w);
      end
      7, 8, 9, 10, 11, 12: begin
        it.command = CMD_P2C;
        if ($urandom_range(0, 3) != 0)
          it.list_position = PosW'($urandom_range(0, board.total + 3));
      end
      default: begin
        it.command = CMD_C2P;
        if ($urandom_range(0, 3) != 0 && board.used > 0)
          it.code_point = CpW'(32'(board.first_tab[$urandom_range(0, board.used - 1)])
                               + $urandom_range(0, 5));
        else it.code_point = CpW'(rand_cp());
      end
    endcase
    return it;
  endfunction

  // Offer one command at the falling edge and hold it until it transfers.
  task automatic send_cmd(in_item_t it);
    @(negedge clk);
    item <= it;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Drop push for a random gap between bursts.
  task automatic idle_gap(int n);
    @(negedge clk);
    push <= 1'b0;
    item <= '0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_burst_list();
    int burst;
    burst = 0;
    while (stim.size() > 0) begin
      send_cmd(stim.pop_front());
      burst++;
      if (burst >= $urandom_range(1, 12)) begin
        burst = 0;
        if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(0, 8));
      end
    end
    idle_gap(0);
  endtask

  // Receiver: stall pattern of its own, plus one long hold-off.
  initial begin
    int phase;
    phase = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      phase++;
      if (hold_off) pop <= 1'b0;
      else if ((phase / 64) % 3 == 0) pop <= 1'b1;
      else pop <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty list lookups, extremes, bad range, full table.
    stim.push_back(make_cmd(CMD_P2C, 0, 0, 0, 0));
    stim.push_back(make_cmd(CMD_C2P, 0, 0, 0, 0));
    stim.push_back(make_cmd(CMD_APPEND, 0, 0, 0, 0));
    stim.push_back(make_cmd(CMD_APPEND, 10, 9, 0, 0));
    stim.push_back(make_cmd(CMD_APPEND, 0, 2**CpW - 1, 0, 0));
    stim.push_back(make_cmd(CMD_APPEND, CpMax, CpMax, 0, 0));
    stim.push_back(make_cmd(CMD_APPEND, 2**CpW - 1, 2**CpW - 1, 0, 0));
    stim.push_back(make_cmd(CMD_P2C, 0, 0, 0, 0));
    stim.push_back(make_cmd(CMD_P2C, 0, 0, 2**CpW, 0));
    stim.push_back(make_cmd(CMD_P2C, 0, 0, 2**CpW + 1, 0));
    stim.push_back(make_cmd(CMD_P2C, 0, 0, 2**CpW + 2, 0));
    stim.push_back(make_cmd(CMD_P2C, 0, 0, 2**PosW - 1, 0));
    stim.push_back(make_cmd(CMD_C2P, 0, 0, 0, CpMax));
    stim.push_back(make_cmd(CMD_C2P, 0, 0, 0, 2**CpW - 1));
    stim.push_back(make_cmd(CMD_CLEAR, 2**CpW - 1, 2**CpW - 1, 2**PosW - 1, 2**CpW - 1));
    stim.push_back(make_cmd(CMD_C2P, 0, 0, 0, 5));
    for (int i = 0; i < MaxRanges; i++)
      stim.push_back(make_cmd(CMD_APPEND, 3 * i, 3 * i + 1, 0, 0));
    stim.push_back(make_cmd(CMD_APPEND, 5, 9, 0, 0));
    stim.push_back(make_cmd(CMD_APPEND, 9, 5, 0, 0));
    stim.push_back(make_cmd(CMD_P2C, 0, 0, 2 * MaxRanges - 1, 0));
    stim.push_back(make_cmd(CMD_C2P, 0, 0, 0, 3 * MaxRanges - 2));
    stim.push_back(make_cmd(CMD_C2P, 0, 0, 0, 2));
    stim.push_back(make_cmd(CMD_CLEAR, 0, 0, 0, 0));
    send_burst_list();

    // Hold off the receiver while the sender keeps offering commands.
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 20; i++) stim.push_back(rand_cmd());
        send_burst_list();
      end
    join

    // Random: generated on the fly so lookups track the current table.
    for (int i = 0; i < NumRandom; i++) begin
      send_cmd(rand_cmd());
      if ($urandom_range(0, 9) == 0) idle_gap($urandom_range(0, 10));
    end
    idle_gap(0);
    stim_done = 1'b1;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (3 * MaxRanges + 20) @(posedge clk);

    $display("sent %0d commands (clear %0d append %0d pos2cp %0d cp2pos %0d), checked %0d",
             sent, board.cmd_seen[0], board.cmd_seen[1], board.cmd_seen[2],
             board.cmd_seen[3], board.checked);
    $display("status mix: ok %0d notfound %0d full %0d badrange %0d",
             board.status_seen[0], board.status_seen[1], board.status_seen[2],
             board.status_seen[3]);
    if (board.errors == 0) $display("tb_range_list_index_map: PASS");
    else $display("tb_range_list_index_map: FAIL");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/rlim_pkg.sv
rtl/rlim_front.sv
rtl/rlim_back.sv
rtl/range_list_index_map.sv
sim/tb_range_list_index_map.sv
